FILE: sv/frl_pkg.sv
// Package for the frame rate limiter: field widths, window depth, spacing constants,
// state codes and the ring index helper.
// No dependencies; frl_if, the core, frl_div and the testbench use it.
package frl_pkg;

   localparam int US_W         = 48;
   localparam int RATE_W       = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int WINDOW_DEPTH = 8;

   localparam longint unsigned SPAN_FULL = 64'd1000000;
   localparam longint unsigned SPAN_MIN  = 64'd900000;

   localparam int CNT_W      = $clog2(WINDOW_DEPTH + 1);
   localparam int IDX_W      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FACTOR_W   = $clog2(WINDOW_DEPTH * SPAN_FULL + 1);
   localparam int DIVIDEND_W = FACTOR_W + RATE_W;
   localparam int STEP_W     = $clog2(DIVIDEND_W);

   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_NUM = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_DEN = CSR_INDEX_W'(1);

   localparam logic [RATE_W-1:0] RATE_NUM_RESET = RATE_W'(30);
   localparam logic [RATE_W-1:0] RATE_DEN_RESET = RATE_W'(1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_MUL    = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_PICK   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   function automatic logic [IDX_W-1:0] ring_wrap(input logic [CNT_W:0] pos);
      logic [CNT_W:0] wrapped;
      wrapped = pos;
      if (pos >= (CNT_W + 1)'(WINDOW_DEPTH)) begin
         wrapped = pos - (CNT_W + 1)'(WINDOW_DEPTH);
      end
      return wrapped[IDX_W-1:0];
   endfunction

endpackage

FILE: sv/frl_if.sv
// Channel interfaces of the frame rate limiter: frame request, decision response
// and register write. Depends on frl_pkg for the field widths.
interface frl_req_if;
   logic                      valid;
   logic                      ready;
   logic [frl_pkg::US_W-1:0]  now_us;
   modport source (output valid, output now_us, input ready);
   modport sink   (input valid, input now_us, output ready);
endinterface

interface frl_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      deliver;
   logic [frl_pkg::US_W-1:0]  next_allowed_us;
   modport source (output valid, output deliver, output next_allowed_us, input ready);
   modport sink   (input valid, input deliver, input next_allowed_us, output ready);
endinterface

interface frl_csr_if;
   logic                             valid;
   logic                             ready;
   logic [frl_pkg::CSR_INDEX_W-1:0]  index;
   logic [frl_pkg::RATE_W-1:0]       data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/frame_rate_limiter_core.sv
// Top level of the frame rate limiter: decision sequencer, pass-time ring and spacing.
// Depends on frl_pkg, frl_if, frl_ram and frl_div.
//
// Each request beat carries one frame arrival time in microseconds; each request
// produces exactly one response beat with the pass/drop decision and the stored
// next-allowed time after that frame. One frame is in work at a time.
// A dropped frame goes from the check state straight to the finish state, which
// loads the response register. A passed frame goes through the check, mul, div,
// pick and finish states: in the div state a bit-serial divider produces one
// quotient bit per cycle for both spacings at once. The next request is
// accepted in the idle state that follows the loading of the response
// register, even if the receiver has not taken it yet; a stalled receiver
// holds a finished response in the finish state.
// The register port takes a write every cycle; the user must write the rate registers
// only while no frame is in work, which the block does not enforce. Reset empties the
// window, zeroes the next-allowed time and restores a rate of 30 over 1.
module frame_rate_limiter_core (
   input  logic       clock,
   input  logic       reset,
   frl_req_if.sink    req_bus,
   frl_rsp_if.source  rsp_bus,
   frl_csr_if.sink    csr_bus
);
   import frl_pkg::*;

   localparam logic [FACTOR_W-1:0]   SPAN_FULL_F = FACTOR_W'(SPAN_FULL);
   localparam logic [DIVIDEND_W-1:0] SPAN_MIN_D  = DIVIDEND_W'(SPAN_MIN);

   state_type             state_ff, state_in;
   logic [RATE_W-1:0]     num_ff, den_ff;
   logic [US_W-1:0]       now_ff;
   logic                  pass_ff;
   logic [FACTOR_W-1:0]   factor_ff;
   logic [US_W-1:0]       base_ff, cand_ff, earl_ff;
   logic [US_W-1:0]       next_time_ff;
   logic [IDX_W-1:0]      head_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_deliver_ff;
   logic [US_W-1:0]       rsp_next_ff;
   logic                  rsp_load;
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [US_W-1:0]       ram_rdata;
   logic                  window_full;
   logic                  div_start, div_done;
   logic [DIVIDEND_W-1:0] dividend_full, dividend_min, quot_full, quot_min;
   logic [RATE_W-1:0]     divisor;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= RATE_NUM_RESET;
         den_ff <= RATE_DEN_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_RATE_NUM: num_ff <= csr_bus.data;
            CSR_RATE_DEN: den_ff <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   assign window_full   = (count_ff >= CNT_W'(WINDOW_DEPTH));
   assign divisor       = (num_ff == '0) ? RATE_W'(1) : num_ff;
   assign dividend_full = {{RATE_W{1'b0}}, factor_ff} * {{FACTOR_W{1'b0}}, den_ff};
   assign dividend_min  = SPAN_MIN_D * {{FACTOR_W{1'b0}}, den_ff};
   assign div_start     = (state_ff == ST_MUL);
   assign ram_we        = (state_ff == ST_PICK);
   assign ram_waddr     = window_full ? head_ff
                        : ring_wrap((CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff));
   assign rsp_load      = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready);

   frl_ram #(.WIDTH(US_W), .DEPTH(WINDOW_DEPTH)) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (now_ff),
      .raddr (head_ff),
      .rdata (ram_rdata)
   );

   frl_div u_div (
      .clock         (clock),
      .reset         (reset),
      .start         (div_start),
      .dividend_full (dividend_full),
      .dividend_min  (dividend_min),
      .divisor       (divisor),
      .done          (div_done),
      .quot_full     (quot_full),
      .quot_min      (quot_min)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_bus.valid) state_in = ST_CHECK;
         ST_CHECK:  state_in = ((count_ff == '0) || (now_ff >= next_time_ff)) ? ST_MUL
                                                                           : ST_FINISH;
         ST_MUL:    state_in = ST_DIV;
         ST_DIV:    if (div_done) state_in = ST_PICK;
         ST_PICK:   state_in = ST_FINISH;
         ST_FINISH: if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_time_ff <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ram_we) begin
            next_time_ff <= (earl_ff >= cand_ff) ? earl_ff : cand_ff;
            if (window_full) begin
               head_ff <= ring_wrap((CNT_W + 1)'(head_ff) + (CNT_W + 1)'(1));
            end else begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         now_ff <= req_bus.now_us;
      end
      if (state_ff == ST_CHECK) begin
         pass_ff   <= (count_ff == '0) || (now_ff >= next_time_ff);
         factor_ff <= FACTOR_W'({{(FACTOR_W - CNT_W){1'b0}}, count_ff} * SPAN_FULL_F);
      end
      if (state_ff == ST_MUL) begin
         base_ff <= (count_ff == '0) ? now_ff : ram_rdata;
      end
      if ((state_ff == ST_DIV) && div_done) begin
         cand_ff <= base_ff + {{(US_W - DIVIDEND_W){1'b0}}, quot_full};
         earl_ff <= now_ff + {{(US_W - DIVIDEND_W){1'b0}}, quot_min};
      end
      if (rsp_load) begin
         rsp_deliver_ff <= pass_ff;
         rsp_next_ff    <= (state_ff == ST_FINISH) ? next_time_ff : rsp_next_ff;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.deliver         = rsp_deliver_ff;
   assign rsp_bus.next_allowed_us = rsp_next_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state register not one-hot");
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW_DEPTH)) else $error("window count overflow");
   a_drop_needs_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_deliver_ff |-> count_ff != '0)
      else $error("frame dropped with an empty window");
   a_head_moves_when_full: assert property (@(posedge clock) disable iff (reset)
      ram_we && !window_full |=> $stable(head_ff)) else $error("head moved while filling");
endmodule

FILE: sv/frl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: sv/frl_div.sv
// Two-lane bit-serial restoring divider sharing one divisor, one quotient bit per cycle.
// Depends on frl_pkg for the dividend width and step counter width.
module frl_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [frl_pkg::DIVIDEND_W-1:0]   dividend_full,
   input  logic [frl_pkg::DIVIDEND_W-1:0]   dividend_min,
   input  logic [frl_pkg::RATE_W-1:0]       divisor,
   output logic                             done,
   output logic [frl_pkg::DIVIDEND_W-1:0]   quot_full,
   output logic [frl_pkg::DIVIDEND_W-1:0]   quot_min
);
   import frl_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [RATE_W-1:0]     divisor_ff, divisor_in;
   logic [DIVIDEND_W-1:0] acc_full_ff, acc_full_in;
   logic [DIVIDEND_W-1:0] acc_min_ff, acc_min_in;
   logic [RATE_W-1:0]     rem_full_ff, rem_full_in;
   logic [RATE_W-1:0]     rem_min_ff, rem_min_in;
   logic [RATE_W:0]       shift_full, shift_min;
   logic                  ge_full, ge_min;

   assign shift_full = {rem_full_ff, acc_full_ff[DIVIDEND_W-1]};
   assign shift_min  = {rem_min_ff, acc_min_ff[DIVIDEND_W-1]};
   assign ge_full    = shift_full >= {1'b0, divisor_ff};
   assign ge_min     = shift_min >= {1'b0, divisor_ff};

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      step_in     = step_ff;
      divisor_in  = divisor_ff;
      acc_full_in = acc_full_ff;
      acc_min_in  = acc_min_ff;
      rem_full_in = rem_full_ff;
      rem_min_in  = rem_min_ff;
      if (start) begin
         busy_in     = 1'b1;
         step_in     = STEP_W'(DIVIDEND_W - 1);
         divisor_in  = divisor;
         acc_full_in = dividend_full;
         acc_min_in  = dividend_min;
         rem_full_in = '0;
         rem_min_in  = '0;
      end else if (busy_ff) begin
         acc_full_in = {acc_full_ff[DIVIDEND_W-2:0], ge_full};
         acc_min_in  = {acc_min_ff[DIVIDEND_W-2:0], ge_min};
         rem_full_in = ge_full ? RATE_W'(shift_full - {1'b0, divisor_ff})
                               : shift_full[RATE_W-1:0];
         rem_min_in  = ge_min ? RATE_W'(shift_min - {1'b0, divisor_ff})
                              : shift_min[RATE_W-1:0];
         step_in     = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff     <= step_in;
      divisor_ff  <= divisor_in;
      acc_full_ff <= acc_full_in;
      acc_min_ff  <= acc_min_in;
      rem_full_ff <= rem_full_in;
      rem_min_ff  <= rem_min_in;
   end

   assign done      = done_ff;
   assign quot_full = acc_full_ff;
   assign quot_min  = acc_min_ff;

   a_rem_full_below: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_full_ff < divisor_ff) else $error("full remainder out of range");
   a_rem_min_below: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_min_ff < divisor_ff) else $error("min remainder out of range");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff) else $error("done without a division");
endmodule

FILE: test/frame_rate_limiter_core_tb.sv
// Testbench for frame_rate_limiter_core: directed and random frame arrivals checked
// beat by beat against an in-bench model of the pass-time window and spacing rule.
// Depends on frl_pkg, frl_if and the block itself.
module frame_rate_limiter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import frl_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_PHASES = 12;
   localparam int FRAMES_PER_PHASE = 155;

   typedef struct packed {
      logic              deliver;
      logic [US_W-1:0]   next_allowed_us;
   } decision_type;

   logic clock;
   logic reset;

   frl_req_if req_if();
   frl_rsp_if rsp_if();
   frl_csr_if csr_if();

   frame_rate_limiter_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // Model state: pass-time ring, fill, next-allowed time and rates.
   logic [US_W-1:0]   win_times [WINDOW_DEPTH];
   int unsigned       win_head;
   int unsigned       win_count;
   logic [US_W-1:0]   next_time;
   logic [RATE_W-1:0] rate_num;
   logic [RATE_W-1:0] rate_den;

   decision_type      expected_decisions[$];
   decision_type      head_decision;
   int                error_count;
   int                cycle_count;
   int                burst_left;
   bit                sender_gaps;
   int                stall_left;
   int                stall_mode;
   int                stall_phase;
   logic [US_W-1:0]   stamp;

   always #1 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic decision_type predict_decision(input logic [US_W-1:0] now);
      decision_type      res;
      longint unsigned   divisor;
      longint unsigned   base;
      longint unsigned   full_span;
      longint unsigned   min_span;
      logic [63:0]       cand;
      logic [63:0]       earliest;
      int unsigned       slot;
      divisor = (rate_num == '0) ? 64'd1 : 64'(rate_num);
      if (win_count != 0 && now < next_time) begin
         res.deliver = 1'b0;
         res.next_allowed_us = next_time;
         return res;
      end
      base = (win_count != 0) ? 64'(win_times[win_head]) : 64'(now);
      full_span = (64'(win_count) * SPAN_FULL * 64'(rate_den)) / divisor;
      min_span = (SPAN_MIN * 64'(rate_den)) / divisor;
      cand = base + full_span;
      earliest = 64'(now) + min_span;
      next_time = (earliest[US_W-1:0] >= cand[US_W-1:0]) ? earliest[US_W-1:0]
                                                          : cand[US_W-1:0];
      if (win_count < WINDOW_DEPTH) begin
         slot = (win_head + win_count) % WINDOW_DEPTH;
         win_times[slot] = now;
         win_count++;
      end else begin
         win_times[win_head] = now;
         win_head = (win_head + 1) % WINDOW_DEPTH;
      end
      res.deliver = 1'b1;
      res.next_allowed_us = next_time;
      return res;
   endfunction

   task automatic push_frame(input logic [US_W-1:0] now);
      int gap;
      req_if.valid <= 1'b1;
      req_if.now_us <= now;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      expected_decisions.push_back(predict_decision(now));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 20);
         if (sender_gaps) begin
            gap = $urandom_range(1, 40);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_decisions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_rates(input logic [RATE_W-1:0] num, input logic [RATE_W-1:0] den);
      wait_idle();
      csr_if.valid <= 1'b1;
      csr_if.index <= CSR_RATE_NUM;
      csr_if.data <= num;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      rate_num = num;
      csr_if.index <= CSR_RATE_DEN;
      csr_if.data <= den;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      rate_den = den;
      csr_if.valid <= 1'b0;
   endtask

   function automatic logic [RATE_W-1:0] pick_rate();
      unique case ($urandom_range(0, 7))
         0: return '0;
         1: return RATE_W'(1);
         2: return '1;
         3, 4: return RATE_W'($urandom_range(1, 240));
         default: return RATE_W'($urandom);
      endcase
   endfunction

   task automatic test_default_rate();
      logic [US_W-1:0] t;
      sender_gaps = 1'b0;
      push_frame(48'd0);
      push_frame(48'd0);
      push_frame(48'd29999);
      push_frame(48'd30000);
      for (int i = 2; i <= 9; i++) begin
         t = US_W'(i * 30000);
         push_frame(t);
      end
      push_frame(48'd400000);
      wait_idle();
   endtask

   task automatic test_rate_extremes();
      sender_gaps = 1'b1;
      write_rates('1, RATE_W'(1));
      push_frame(48'd1000000);
      push_frame(48'd1000013);
      write_rates(RATE_W'(1), '1);
      push_frame(48'hFFFF_FFFF_0000);
      push_frame(48'hFFFF_FFFF_FFFF);
      push_frame(48'd5);
      write_rates('0, '0);
      push_frame(48'd100);
      push_frame(48'd100);
      push_frame(48'd50);
      write_rates('1, '1);
      push_frame(48'd200);
      push_frame(48'd2000000);
      wait_idle();
   endtask

   task automatic test_random_traffic();
      longint unsigned span;
      longint unsigned step;
      int              roll;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         write_rates(pick_rate(), pick_rate());
         sender_gaps = ($urandom_range(0, 3) != 0);
         span = (SPAN_FULL * 64'(rate_den)) / ((rate_num == '0) ? 64'd1 : 64'(rate_num));
         for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
               stamp = US_W'({$urandom, $urandom});
            end else if (roll == 1) begin
               stamp = stamp - US_W'($urandom_range(1, 100000));
            end else begin
               if (span == 0) begin
                  step = $urandom_range(0, 50);
               end else begin
                  step = (span * $urandom_range(0, 2000)) / 1000;
               end
               stamp = stamp + US_W'(step);
            end
            push_frame(stamp);
         end
      end
      wait_idle();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_decisions.size() == 0) begin
            report_mismatch($sformatf("unexpected beat deliver=%0b next=%0d",
                                      rsp_if.deliver, rsp_if.next_allowed_us));
         end else begin
            head_decision = expected_decisions.pop_front();
            if (rsp_if.deliver !== head_decision.deliver) begin
               report_mismatch($sformatf("deliver got %0b exp %0b",
                                         rsp_if.deliver, head_decision.deliver));
            end
            if (rsp_if.next_allowed_us !== head_decision.next_allowed_us) begin
               report_mismatch($sformatf("next_allowed_us got %0d exp %0d",
                                         rsp_if.next_allowed_us,
                                         head_decision.next_allowed_us));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_phase == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_phase <= 300;
      end else begin
         stall_phase <= stall_phase - 1;
      end
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (stall_mode != 0 && $urandom_range(0, (stall_mode == 1) ? 7 : 1) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.now_us = '0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_RATE_NUM;
      csr_if.data = '0;
      rsp_if.ready = 1'b0;
      stall_left = 0;
      stall_mode = 0;
      stall_phase = 0;
      cycle_count = 0;
      error_count = 0;
      burst_left = 0;
      sender_gaps = 1'b0;
      stamp = '0;
      win_head = 0;
      win_count = 0;
      next_time = '0;
      rate_num = RATE_NUM_RESET;
      rate_den = RATE_DEN_RESET;
      for (int i = 0; i < WINDOW_DEPTH; i++) win_times[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_rate();
      test_rate_extremes();
      stamp = 48'd3000000;
      test_random_traffic();

      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_decisions.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
